[hdl/bed_pkg.sv]
`timescale 1ns / 1ps

package bed_pkg;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_ESC    = 2'd1;
  localparam logic [1:0] MODE_OCT    = 2'd2;
  localparam logic [1:0] MODE_HEX    = 2'd3;

  localparam logic [1:0] OCT_DIGITS_MAX = 2'd3;
  localparam logic [1:0] HEX_DIGITS_MAX = 2'd2;

  localparam int unsigned BURST_MAX = 3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_final;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_run_end;
    logic       out_final;
  } out_item_t;

  typedef struct packed {
    logic [BURST_MAX-1:0][7:0] bytes;
    logic [1:0]                cnt;
    logic                      fin;
  } burst_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] dcnt;
  } dec_stat_t;

  typedef struct packed {
    logic a_valid;
    logic b_valid;
    logic a_free;
  } q_stat_t;

endpackage

[hdl/bed_decode.sv]
`timescale 1ns / 1ps

module bed_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  bed_pkg::in_item_t item,
  output bed_pkg::burst_t   burst,
  output bed_pkg::dec_stat_t stat
);
  import bed_pkg::*;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] ESC_BYTE  = 8'h1B;

  logic [1:0] mode_r, mode_nxt;
  logic [8:0] dval_r, dval_nxt;
  logic [1:0] dcnt_r, dcnt_nxt;

  logic [BURST_MAX-1:0][7:0] b;
  logic [1:0] n;
  logic       do_plain;
  logic       hex_ok;
  logic [3:0] hex_d;
  logic [7:0] c;
  logic       fin;

  assign c   = item.in_byte;
  assign fin = item.in_final;

  always_comb begin
    hex_ok = 1'b1;
    hex_d  = c[3:0];
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_d = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      hex_d = c[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    b        = '0;
    n        = 2'd0;
    do_plain = 1'b0;
    mode_nxt = mode_r;
    dval_nxt = dval_r;
    dcnt_nxt = dcnt_r;
    case (mode_r)
      MODE_ESC: begin
        mode_nxt = MODE_NORMAL;
        case (c)
          8'h5C: begin b[n] = CH_BSLASH; n = n + 2'd1; end
          8'h61: begin b[n] = 8'h07; n = n + 2'd1; end
          8'h62: begin b[n] = 8'h08; n = n + 2'd1; end
          8'h65: begin b[n] = ESC_BYTE; n = n + 2'd1; end
          8'h66: begin b[n] = 8'h0C; n = n + 2'd1; end
          8'h6E: begin b[n] = 8'h0A; n = n + 2'd1; end
          8'h72: begin b[n] = 8'h0D; n = n + 2'd1; end
          8'h74: begin b[n] = 8'h09; n = n + 2'd1; end
          8'h76: begin b[n] = 8'h0B; n = n + 2'd1; end
          8'h30: begin
            dval_nxt = '0;
            dcnt_nxt = '0;
            if (fin) begin
              b[n] = 8'h00;
              n = n + 2'd1;
            end else begin
              mode_nxt = MODE_OCT;
            end
          end
          8'h78: begin
            dval_nxt = '0;
            dcnt_nxt = '0;
            if (fin) begin
              b[n] = CH_BSLASH;
              n = n + 2'd1;
              b[n] = CH_X;
              n = n + 2'd1;
            end else begin
              mode_nxt = MODE_HEX;
            end
          end
          default: begin
            b[n] = CH_BSLASH;
            n = n + 2'd1;
            do_plain = 1'b1;
          end
        endcase
      end
      MODE_OCT: begin
        if (c >= CH_ZERO && c <= 8'h37) begin
          dval_nxt = {dval_r[5:0], c[2:0]};
          dcnt_nxt = dcnt_r + 2'd1;
          if (dcnt_nxt >= OCT_DIGITS_MAX || fin) begin
            b[n] = dval_nxt[7:0];
            n = n + 2'd1;
            mode_nxt = MODE_NORMAL;
          end
        end else begin
          b[n] = dval_r[7:0];
          n = n + 2'd1;
          do_plain = 1'b1;
        end
      end
      MODE_HEX: begin
        if (hex_ok) begin
          dval_nxt = {dval_r[4:0], hex_d};
          dcnt_nxt = dcnt_r + 2'd1;
          if (dcnt_nxt >= HEX_DIGITS_MAX || fin) begin
            b[n] = dval_nxt[7:0];
            n = n + 2'd1;
            mode_nxt = MODE_NORMAL;
          end
        end else begin
          if (dcnt_r != 2'd0) begin
            b[n] = dval_r[7:0];
            n = n + 2'd1;
          end else begin
            b[n] = CH_BSLASH;
            n = n + 2'd1;
            b[n] = CH_X;
            n = n + 2'd1;
          end
          do_plain = 1'b1;
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase

    if (do_plain) begin
      if (c == CH_BSLASH && !fin) begin
        mode_nxt = MODE_ESC;
      end else begin
        mode_nxt = MODE_NORMAL;
        b[n] = c;
        n = n + 2'd1;
      end
    end

    if (mode_nxt == MODE_NORMAL || fin) begin
      mode_nxt = MODE_NORMAL;
      dval_nxt = '0;
      dcnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      dval_r <= '0;
      dcnt_r <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      dval_r <= dval_nxt;
      dcnt_r <= dcnt_nxt;
    end
  end

  assign burst.bytes = b;
  assign burst.cnt   = n;
  assign burst.fin   = fin;
  assign stat.mode   = mode_r;
  assign stat.dcnt   = dcnt_r;

endmodule

[hdl/bed_serializer.sv]
`timescale 1ns / 1ps

module bed_serializer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bed_pkg::burst_t    burst,
  output logic               out_valid,
  input  logic               out_stall,
  output bed_pkg::out_item_t out_item,
  output bed_pkg::q_stat_t   stat
);
  import bed_pkg::*;

  logic   a_valid_r, a_valid_nxt;
  logic   b_valid_r, b_valid_nxt;
  burst_t a_r, a_nxt;
  burst_t b_r, b_nxt;
  logic [1:0] idx_r, idx_nxt;

  logic a_take;
  logic a_last;
  logic a_free;

  assign a_take = a_valid_r && !out_stall;
  assign a_last = (idx_r == a_r.cnt - 2'd1);
  assign a_free = !a_valid_r || (a_take && a_last);

  always_comb begin
    a_valid_nxt = a_valid_r;
    b_valid_nxt = b_valid_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    idx_nxt     = idx_r;
    if (a_free) begin
      idx_nxt = 2'd0;
      if (b_valid_r) begin
        a_valid_nxt = 1'b1;
        a_nxt       = b_r;
        b_valid_nxt = push;
        b_nxt       = burst;
      end else begin
        a_valid_nxt = push;
        a_nxt       = burst;
      end
    end else begin
      if (a_take) begin
        idx_nxt = idx_r + 2'd1;
      end
      if (push) begin
        b_valid_nxt = 1'b1;
        b_nxt       = burst;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      idx_r     <= 2'd0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
      idx_r     <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  assign out_valid            = a_valid_r;
  assign out_item.out_byte    = a_r.bytes[idx_r];
  assign out_item.out_run_end = a_last;
  assign out_item.out_final   = a_last && a_r.fin;
  assign stat.a_valid         = a_valid_r;
  assign stat.b_valid         = b_valid_r;
  assign stat.a_free          = a_free;

endmodule

[hdl/backslash_escape_decoder.sv]
`timescale 1ns / 1ps

// Channel  Direction  Payload    Handshake
// in_      input      in_item    in_valid / in_stall
// out_     output     out_item   out_valid / out_stall
//
// One byte is decoded in the cycle it is accepted; its 0 to 3 result bytes
// leave one per cycle from the result register while out_stall is low: one
// result byte for plain text, up to 3 for a byte after \x.
// A two-slot burst queue lets one more byte be accepted while results wait.
// rst_n is synchronous and clears the parse state and both queue slots.
// in_stall rises only when both slots hold bursts and the output one is
// not finishing in this cycle.

module backslash_escape_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bed_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output bed_pkg::out_item_t out_item
);
  import bed_pkg::*;

  logic      in_acc;
  logic      push;
  burst_t    burst;
  dec_stat_t dstat;
  q_stat_t   qstat;

  assign in_stall = qstat.b_valid && !qstat.a_free;
  assign in_acc   = in_valid && !in_stall;
  assign push     = in_acc && (burst.cnt != 2'd0);

  bed_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_acc),
    .item   (in_item),
    .burst  (burst),
    .stat   (dstat)
  );

  bed_serializer u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .burst     (burst),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .stat      (qstat)
  );

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.b_valid |-> qstat.a_valid)
    else $error("pending slot full while output slot empty");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_item.in_final) |=> (dstat.mode == MODE_NORMAL && dstat.dcnt == 2'd0))
    else $error("parse state not cleared after final byte");

  a_final_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_item.in_final) |-> push)
    else $error("final byte caused no result");

endmodule
